// File: hdl/kmsd_pkg.sv
// ---------------------------------------------------------------------------
// kmsd_pkg
// Shared widths and reset value for the key matrix scanner with debounce.
// ---------------------------------------------------------------------------
package kmsd_pkg;

  localparam int NUM_COLUMNS_DEF = 7;
  localparam int NUM_ROWS_DEF    = 5;

  // fixed word field and counter widths
  localparam int SAMPLE_W  = 5;
  localparam int COL_OUT_W = 3;
  localparam int CNT_W     = 8;
  localparam int CFG_W     = 8;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 8'd5;

endpackage

// File: hdl/kmsd_if.sv
// ---------------------------------------------------------------------------
// kmsd channel interfaces
// Valid/ready channels for row samples, scan results and the config write.
// ---------------------------------------------------------------------------
interface kmsd_sample_if;
  logic                          valid;
  logic                          ready;
  logic [kmsd_pkg::SAMPLE_W-1:0] row_sample;

  modport source (output valid, output row_sample, input ready);
  modport sink   (input valid, input row_sample, output ready);
endinterface

interface kmsd_result_if;
  logic                           valid;
  logic                           ready;
  logic [kmsd_pkg::COL_OUT_W-1:0] scanned_column;
  logic [kmsd_pkg::SAMPLE_W-1:0]  debounced_rows;
  logic [kmsd_pkg::SAMPLE_W-1:0]  toggled_rows;
  logic [kmsd_pkg::COL_OUT_W-1:0] next_column;

  modport source (output valid, output scanned_column, output debounced_rows,
                  output toggled_rows, output next_column, input ready);
  modport sink   (input valid, input scanned_column, input debounced_rows,
                  input toggled_rows, input next_column, output ready);
endinterface

interface kmsd_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [kmsd_pkg::CFG_W-1:0] debounce_samples;

  modport source (output valid, output debounce_samples, input ready);
  modport sink   (input valid, input debounce_samples, output ready);
endinterface

// File: hdl/key_matrix_scan_debounce.sv
// ---------------------------------------------------------------------------
// key_matrix_scan_debounce
// Keyboard matrix scanner with per-key counter debounce.
//
// samples: one word per scan tick, the row levels read while the current
//   column is driven. results: one word per sample with the scanned column,
//   its debounced rows, the rows that toggled, and the column to drive next.
// cfg: write-only debounce_samples register (reset 5), always ready; write
//   it only while no sample is in flight.
// Latency: the result appears in the cycle after the sample is taken.
// Throughput: one sample per cycle; column state sits in flops indexed by
//   the column counter, updated in the same cycle as the sample is taken.
// A held result register frees as it is taken, so a sample can enter in the
//   same cycle that the previous result leaves. While the receiver stalls
//   with a result pending, samples.ready is low.
// Reset (rst, synchronous): column counter to zero, all debounced states,
//   previous samples and counters cleared, debounce_samples back to 5.
// Counters are 8 bits and wrap; a threshold of zero acts as one.
// ---------------------------------------------------------------------------
module key_matrix_scan_debounce #(
  parameter int NUM_COLUMNS = kmsd_pkg::NUM_COLUMNS_DEF,
  parameter int NUM_ROWS    = kmsd_pkg::NUM_ROWS_DEF
) (
  input logic         clk,
  input logic         rst,
  kmsd_sample_if.sink samples,
  kmsd_result_if.source results,
  kmsd_cfg_if.sink    cfg
);
  import kmsd_pkg::*;

  localparam int COL_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(NUM_COLUMNS - 1);

  // state
  logic [COL_W-1:0]                 col_idx;
  logic [COL_W-1:0]                 col_idx_next;
  logic [CFG_W-1:0]                 threshold;
  logic [NUM_ROWS-1:0]              deb_mem  [NUM_COLUMNS];
  logic [NUM_ROWS-1:0]              prev_mem [NUM_COLUMNS];
  logic [NUM_ROWS-1:0][CNT_W-1:0]   cnt_mem  [NUM_COLUMNS];

  // result register
  logic                 out_valid;
  logic [COL_OUT_W-1:0] out_col;
  logic [SAMPLE_W-1:0]  out_deb;
  logic [SAMPLE_W-1:0]  out_tog;
  logic [COL_OUT_W-1:0] out_next;

  logic                           in_fire;
  logic [NUM_ROWS-1:0]            rows;
  logic [NUM_ROWS-1:0]            state_next;
  logic [NUM_ROWS-1:0]            toggled;
  logic [NUM_ROWS-1:0][CNT_W-1:0] cnt_next;
  logic [SAMPLE_W-1:0]            deb_word;
  logic [SAMPLE_W-1:0]            tog_word;
  logic [COL_OUT_W-1:0]           col_word;
  logic [COL_OUT_W-1:0]           next_word;

  function automatic logic [SAMPLE_W-1:0] tog_word_mask();
    logic [SAMPLE_W-1:0] m;
    m = '0;
    for (int i = 0; i < SAMPLE_W; i++) begin
      if (i < NUM_ROWS) begin
        m[i] = 1'b1;
      end
    end
    return m;
  endfunction

  assign samples.ready = !out_valid || results.ready;
  assign in_fire       = samples.valid && samples.ready;
  assign cfg.ready     = 1'b1;

  assign col_idx_next = (col_idx == COL_LAST) ? '0 : col_idx + 1'b1;

  // rows beyond the sample width read as zero; result bits beyond NUM_ROWS are zero
  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_rows_in
    if (r < SAMPLE_W) begin : g_bit
      assign rows[r] = samples.row_sample[r];
    end else begin : g_zero
      assign rows[r] = 1'b0;
    end
  end

  for (genvar i = 0; i < SAMPLE_W; i++) begin : g_rows_out
    if (i < NUM_ROWS) begin : g_bit
      assign deb_word[i] = state_next[i];
      assign tog_word[i] = toggled[i];
    end else begin : g_zero
      assign deb_word[i] = 1'b0;
      assign tog_word[i] = 1'b0;
    end
  end

  if (COL_W >= COL_OUT_W) begin : g_col_trunc
    assign col_word  = col_idx[COL_OUT_W-1:0];
    assign next_word = col_idx_next[COL_OUT_W-1:0];
  end else begin : g_col_ext
    assign col_word  = {{(COL_OUT_W - COL_W){1'b0}}, col_idx};
    assign next_word = {{(COL_OUT_W - COL_W){1'b0}}, col_idx_next};
  end

  kmsd_col_update #(
    .NUM_ROWS (NUM_ROWS)
  ) u_update (
    .rows       (rows),
    .state      (deb_mem[col_idx]),
    .prev       (prev_mem[col_idx]),
    .cnt        (cnt_mem[col_idx]),
    .threshold  (threshold),
    .state_next (state_next),
    .cnt_next   (cnt_next),
    .toggled    (toggled)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= DEBOUNCE_RESET;
    end else if (cfg.valid) begin
      threshold <= cfg.debounce_samples;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_idx <= '0;
      for (int c = 0; c < NUM_COLUMNS; c++) begin
        deb_mem[c]  <= '0;
        prev_mem[c] <= '0;
        cnt_mem[c]  <= '0;
      end
    end else if (in_fire) begin
      col_idx           <= col_idx_next;
      deb_mem[col_idx]  <= state_next;
      prev_mem[col_idx] <= rows;
      cnt_mem[col_idx]  <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_col  <= col_word;
      out_deb  <= deb_word;
      out_tog  <= tog_word;
      out_next <= next_word;
    end
  end

  assign results.valid          = out_valid;
  assign results.scanned_column = out_col;
  assign results.debounced_rows = out_deb;
  assign results.toggled_rows   = out_tog;
  assign results.next_column    = out_next;

  // checks
  a_col_range: assert property (@(posedge clk) disable iff (rst)
    col_idx <= COL_LAST)
    else $error("column counter out of range");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> results.valid)
    else $error("accepted sample produced no result");

  a_next_matches: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> (results.next_column == col_word))
    else $error("next_column disagrees with column counter");

  a_no_take_when_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !results.ready) |-> !in_fire)
    else $error("sample taken over a pending result");

  a_toggle_in_state: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> ((results.toggled_rows & ~tog_word_mask()) == '0))
    else $error("toggle reported on a row outside the matrix");

endmodule

// File: hdl/kmsd_col_update.sv
// ---------------------------------------------------------------------------
// kmsd_col_update
// Per-key debounce update for one column: counters, toggles, new state.
// ---------------------------------------------------------------------------
module kmsd_col_update #(
  parameter int NUM_ROWS = kmsd_pkg::NUM_ROWS_DEF
) (
  input  logic [NUM_ROWS-1:0]                     rows,
  input  logic [NUM_ROWS-1:0]                     state,
  input  logic [NUM_ROWS-1:0]                     prev,
  input  logic [NUM_ROWS-1:0][kmsd_pkg::CNT_W-1:0] cnt,
  input  logic [kmsd_pkg::CFG_W-1:0]              threshold,
  output logic [NUM_ROWS-1:0]                     state_next,
  output logic [NUM_ROWS-1:0][kmsd_pkg::CNT_W-1:0] cnt_next,
  output logic [NUM_ROWS-1:0]                     toggled
);
  import kmsd_pkg::*;

  logic [NUM_ROWS-1:0] steady;
  logic [NUM_ROWS-1:0][CNT_W-1:0] cnt_inc;

  // differs from debounced state and unchanged since last visit
  assign steady = (rows ^ state) & ~(rows ^ prev);

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      cnt_inc[r]    = cnt[r] + 1'b1;  // wraps at 8 bits
      toggled[r]    = 1'b0;
      cnt_next[r]   = '0;
      if (steady[r]) begin
        if (cnt_inc[r] >= threshold) begin
          toggled[r] = 1'b1;
        end else begin
          cnt_next[r] = cnt_inc[r];
        end
      end
    end
    state_next = state ^ toggled;
  end

endmodule

// File: tb/kmsd_scan_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// kmsd_scan_checker
// Passive checker for the key matrix scanner. It tracks the debounce
// threshold and the per-column key state, and predicts one result word for
// every accepted sample word. It compares each result word field by field
// with the oldest prediction. It reports the error count and the number of
// result words still outstanding.
// ---------------------------------------------------------------------------
module kmsd_scan_checker
  import kmsd_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  kmsd_sample_if smp,
  kmsd_result_if res,
  kmsd_cfg_if    cfg,
  output int     n_errors,
  output int     n_pending
);

  typedef struct packed {
    logic [COL_OUT_W-1:0] column;
    logic [SAMPLE_W-1:0]  debounced;
    logic [SAMPLE_W-1:0]  toggled;
    logic [COL_OUT_W-1:0] next_col;
  } scan_word_t;

  localparam logic [SAMPLE_W-1:0] ROW_MASK = SAMPLE_W'((1 << NUM_ROWS_DEF) - 1);

  logic [CFG_W-1:0]    debounce_thr;
  int unsigned         scan_col;
  logic [SAMPLE_W-1:0] deb_rows  [NUM_COLUMNS_DEF];
  logic [SAMPLE_W-1:0] last_raw  [NUM_COLUMNS_DEF];
  logic [CNT_W-1:0]    key_count [NUM_COLUMNS_DEF][NUM_ROWS_DEF];
  scan_word_t          expected_scans[$];
  int                  err_total  = 0;
  int                  pend_total = 0;

  assign n_errors  = err_total;
  assign n_pending = pend_total;

  // one scan tick: update the scanned column and return its result word
  function automatic scan_word_t debounce_scan(input logic [SAMPLE_W-1:0] raw_in);
    int unsigned         col;
    int unsigned         nxt;
    logic [SAMPLE_W-1:0] raw;
    logic [SAMPLE_W-1:0] state;
    logic [SAMPLE_W-1:0] steady;
    logic [SAMPLE_W-1:0] toggled;
    scan_word_t          w;
    col     = scan_col;
    raw     = raw_in & ROW_MASK;
    state   = deb_rows[col];
    // differs from debounced state and unchanged since the last visit
    steady  = (raw ^ state) & ~(raw ^ last_raw[col]) & ROW_MASK;
    toggled = '0;
    for (int r = 0; r < NUM_ROWS_DEF; r++) begin
      if (steady[r]) begin
        key_count[col][r] = key_count[col][r] + 1'b1;
        // >= so that a threshold of zero acts as one
        if (key_count[col][r] >= debounce_thr) begin
          state[r]          = ~state[r];
          toggled[r]        = 1'b1;
          key_count[col][r] = '0;
        end
      end else begin
        key_count[col][r] = '0;
      end
    end
    deb_rows[col] = state;
    last_raw[col] = raw;
    nxt = (col + 1 >= NUM_COLUMNS_DEF) ? 0 : col + 1;
    scan_col = nxt;
    w.column    = COL_OUT_W'(col);
    w.debounced = state;
    w.toggled   = toggled;
    w.next_col  = COL_OUT_W'(nxt);
    return w;
  endfunction

  function automatic void check_field(input string name, input int unsigned exp_val,
                                      input int unsigned act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      err_total++;
    end
  endfunction

  always @(posedge clk) begin
    scan_word_t exp_w;
    if (rst) begin
      debounce_thr = DEBOUNCE_RESET;
      scan_col     = 0;
      for (int c = 0; c < NUM_COLUMNS_DEF; c++) begin
        deb_rows[c] = '0;
        last_raw[c] = '0;
        for (int r = 0; r < NUM_ROWS_DEF; r++) key_count[c][r] = '0;
      end
      expected_scans.delete();
    end else begin
      if (res.valid && res.ready) begin
        if (expected_scans.size() == 0) begin
          $error("result word with no sample word outstanding");
          err_total++;
        end else begin
          exp_w = expected_scans.pop_front();
          check_field("scanned_column", 32'(exp_w.column),    32'(res.scanned_column));
          check_field("debounced_rows", 32'(exp_w.debounced), 32'(res.debounced_rows));
          check_field("toggled_rows",   32'(exp_w.toggled),   32'(res.toggled_rows));
          check_field("next_column",    32'(exp_w.next_col),  32'(res.next_column));
        end
      end
      if (cfg.valid && cfg.ready) debounce_thr = cfg.debounce_samples;
      if (smp.valid && smp.ready) expected_scans.push_back(debounce_scan(smp.row_sample));
    end
    pend_total <= expected_scans.size();
  end

endmodule

// File: tb/key_matrix_scan_debounce_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// key_matrix_scan_debounce_tb
// Stimulus and verdict for the key matrix scanner. Sample words come from
// held key patterns per column with bounce noise, under several debounce
// thresholds that include zero, one and 255. Sender and receiver stall at
// random in most phases. Checking is done in kmsd_scan_checker.
// ---------------------------------------------------------------------------
module key_matrix_scan_debounce_tb;
  import kmsd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int END_CYCLES  = 4;

  logic clk = 1'b0;
  logic rst;

  kmsd_sample_if smp();
  kmsd_result_if res();
  kmsd_cfg_if    cfg_ch();

  int                  n_errors;
  int                  n_pending;
  int                  src_idle     = 38;
  int                  dst_idle     = 67;
  int                  quiet_cycles = 0;
  int unsigned         drive_col    = 0;
  logic [SAMPLE_W-1:0] key_target [NUM_COLUMNS_DEF];

  key_matrix_scan_debounce u_top (
    .clk     (clk),
    .rst     (rst),
    .samples (smp),
    .results (res),
    .cfg     (cfg_ch)
  );

  kmsd_scan_checker u_check (
    .clk       (clk),
    .rst       (rst),
    .smp       (smp),
    .res       (res),
    .cfg       (cfg_ch),
    .n_errors  (n_errors),
    .n_pending (n_pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk);
      res.ready <= ($urandom_range(0, 99) >= dst_idle);
    end
  end

  // watchdog: cycles with no word moving on any channel
  always @(posedge clk) begin
    if ((smp.valid && smp.ready) || (res.valid && res.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic idle_gap();
    while ($urandom_range(0, 99) < src_idle) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // leaves valid high on return, so back-to-back words need no extra edge
  task automatic send_word(input logic [SAMPLE_W-1:0] word);
    smp.valid      <= 1'b1;
    smp.row_sample <= word;
    do @(posedge clk); while (!smp.ready);
    drive_col = (drive_col + 1) % NUM_COLUMNS_DEF;
  endtask

  task automatic drain();
    smp.valid <= 1'b0;
    do @(posedge clk); while (n_pending != 0);
  endtask

  task automatic write_threshold(input logic [CFG_W-1:0] thr);
    drain();
    cfg_ch.valid            <= 1'b1;
    cfg_ch.debounce_samples <= thr;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // held key patterns with occasional key changes and bounce noise
  task automatic run_keys(input int n_items, input int noise_pct, input int change_pct);
    logic [SAMPLE_W-1:0] word;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2 || $urandom_range(0, 49) == 0) drain();
      idle_gap();
      if ($urandom_range(0, 99) < change_pct) begin
        key_target[drive_col] ^= SAMPLE_W'(1) << $urandom_range(0, NUM_ROWS_DEF - 1);
      end
      word = key_target[drive_col];
      if ($urandom_range(0, 99) < noise_pct) word = SAMPLE_W'($urandom_range(0, 31));
      send_word(word);
    end
  endtask

  initial begin
    logic [SAMPLE_W-1:0] corner_words [7];
    corner_words = '{5'b00000, 5'b11111, 5'b10101, 5'b01010,
                     5'b00001, 5'b10000, 5'b00000};
    rst                     <= 1'b1;
    smp.valid               <= 1'b0;
    smp.row_sample          <= '0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.debounce_samples <= '0;
    foreach (key_target[c]) key_target[c] = SAMPLE_W'($urandom_range(0, 31));
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed: zero threshold, all keys down for two visits, then corners
    write_threshold(8'd0);
    repeat (2 * NUM_COLUMNS_DEF) begin
      idle_gap();
      send_word('1);
    end
    foreach (corner_words[k]) begin
      idle_gap();
      send_word(corner_words[k]);
    end

    write_threshold(8'd1);
    run_keys(150, 10, 15);
    write_threshold(8'd3);
    run_keys(150, 10, 10);

    src_idle = 67;
    dst_idle = 38;
    // max threshold: keys held with no noise, counts stay short of it
    write_threshold(8'd255);
    run_keys(130, 0, 0);
    write_threshold(8'd2);
    run_keys(150, 10, 20);

    src_idle = 0;
    dst_idle = 0;
    write_threshold(DEBOUNCE_RESET);
    run_keys(150, 10, 10);
    write_threshold(CFG_W'($urandom_range(4, 12)));
    run_keys(150, 5, 5);
    write_threshold(8'd1);
    run_keys(100, 100, 0);

    drain();
    repeat (END_CYCLES) @(posedge clk);
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
